>>> design/gda_pkg.sv
package gda_pkg;

  typedef enum logic [1:0] {
    FUNC_VALIDATE = 2'd0,
    FUNC_COMPARE  = 2'd1,
    FUNC_DIFF     = 2'd2,
    FUNC_NEXT     = 2'd3
  } func_e;

  localparam logic [1:0] ORDER_EARLIER = 2'd0;
  localparam logic [1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [1:0] ORDER_LATER   = 2'd2;

  localparam int unsigned YearW = 14;
  localparam int unsigned OrdW  = 23;
  localparam int unsigned Q100W = 8;

  typedef struct packed {
    func_e             func;
    logic [4:0]        day_a;
    logic [3:0]        month_a;
    logic [YearW-1:0]  year_a;
    logic [4:0]        day_b;
    logic [3:0]        month_b;
    logic [YearW-1:0]  year_b;
  } req_t;

  typedef struct packed {
    logic              is_valid;
    logic [1:0]        order;
    logic [21:0]       day_count;
    logic [5:0]        next_day;
    logic [3:0]        next_month;
    logic [YearW-1:0]  next_year;
  } res_t;

  // per-date results of the ordinal stage
  typedef struct packed {
    logic              leap;
    logic [4:0]        mlen;
    logic [OrdW-1:0]   ordinal;
  } date_info_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13:   r = 9'd365;
      4'd14:   r = 9'd395;
      4'd15:   r = 9'd425;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd30;
    endcase
    return r;
  endfunction

endpackage

>>> design/gda_year_split.sv
module gda_year_split (
  input  logic [gda_pkg::YearW-1:0] year_i,
  output logic [gda_pkg::Q100W-1:0] q100_o
);
  import gda_pkg::*;

  // floor(y / 100) as y * 5243 / 2^19, exact for all 14-bit years
  logic [26:0] prod;

  assign prod   = 27'(year_i) * 27'd5243;
  assign q100_o = prod[26:19];

endmodule

>>> design/gda_ordinal.sv
module gda_ordinal (
  input  logic [gda_pkg::YearW-1:0] year_i,
  input  logic [gda_pkg::Q100W-1:0] q100_i,
  input  logic [3:0]                month_i,
  input  logic [4:0]                day_i,
  output gda_pkg::date_info_t       info_o
);
  import gda_pkg::*;

  logic              div4, div100, div400, leap;
  logic [14:0]       back100;
  logic [12:0]       y4;
  logic [Q100W-1:0]  y100;
  logic [5:0]        y400;
  logic [OrdW-1:0]   dby;

  assign div4    = (year_i[1:0] == 2'd0);
  assign back100 = 15'(q100_i) * 15'd100;
  assign div100  = (back100 == 15'(year_i));
  assign div400  = div100 && (q100_i[1:0] == 2'd0);
  assign leap    = div400 || (div4 && !div100);

  // ceil(y/4), ceil(y/100), ceil(y/400)
  assign y4   = 13'(year_i[YearW-1:2]) + 13'(!div4);
  assign y100 = q100_i + Q100W'(!div100);
  assign y400 = 6'(q100_i[Q100W-1:2]) + 6'(!div400);

  assign dby = OrdW'(year_i) * OrdW'(365) + OrdW'(y4) - OrdW'(y100) + OrdW'(y400);

  assign info_o.leap    = leap;
  assign info_o.mlen    = month_length(month_i, leap);
  assign info_o.ordinal = dby + OrdW'(days_before_month(month_i)) + OrdW'(day_i)
                        + OrdW'((month_i > 4'd2) && leap);

endmodule

>>> design/gregorian_date_arithmetic_unit.sv
// Gregorian date arithmetic unit, three register stages.
// done_o rises once a request has passed the stage 1, stage 2 and output
// registers; the receiver cannot hold results off.
// Throughput: one request per cycle; busy_o stays low since nothing stalls.
// Reset (rst_ni low, asynchronous) drops all in-flight requests; payload
// registers are not reset.
module gregorian_date_arithmetic_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  gda_pkg::req_t  req_i,
  output logic           done_o,
  output gda_pkg::res_t  res_o
);
  import gda_pkg::*;

  // Stage 1: split years by 100, order the dates.
  logic              v1_q;
  req_t              r1_q;
  logic [Q100W-1:0]  qa1_q, qb1_q;
  logic [1:0]        ord1_q;
  logic [Q100W-1:0]  qa_d, qb_d;
  logic [1:0]        ord_d;

  // Stage 2: leap rule, day ordinals, validity and following date.
  logic              v2_q;
  func_e             f2_q;
  logic [1:0]        ord2_q;
  logic              ok2_q;
  logic [5:0]        nd2_q;
  logic [3:0]        nm2_q;
  logic [YearW-1:0]  ny2_q;
  logic [OrdW-1:0]   oa2_q, ob2_q;

  date_info_t        info_a, info_b;
  logic              ok_d;
  logic [5:0]        nd_d;
  logic [4:0]        nm_d;
  logic [YearW-1:0]  ny_d;

  // Stage 3: output register.
  logic              done_q;
  res_t              res_q;
  res_t              res_d;
  logic [OrdW-1:0]   diff;

  // The pipeline never stalls, so a request is always taken.
  assign busy_o = 1'b0;

  gda_year_split u_split_a (.year_i(req_i.year_a), .q100_o(qa_d));
  gda_year_split u_split_b (.year_i(req_i.year_b), .q100_o(qb_d));

  // Compare ignores validity: year, then month, then day.
  always_comb begin
    ord_d = ORDER_EQUAL;
    if (req_i.year_a != req_i.year_b) begin
      ord_d = (req_i.year_a > req_i.year_b) ? ORDER_LATER : ORDER_EARLIER;
    end else if (req_i.month_a != req_i.month_b) begin
      ord_d = (req_i.month_a > req_i.month_b) ? ORDER_LATER : ORDER_EARLIER;
    end else if (req_i.day_a != req_i.day_b) begin
      ord_d = (req_i.day_a > req_i.day_b) ? ORDER_LATER : ORDER_EARLIER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q   <= req_i;
    qa1_q  <= qa_d;
    qb1_q  <= qb_d;
    ord1_q <= ord_d;
  end

  gda_ordinal u_ord_a (
    .year_i (r1_q.year_a),
    .q100_i (qa1_q),
    .month_i(r1_q.month_a),
    .day_i  (r1_q.day_a),
    .info_o (info_a)
  );

  gda_ordinal u_ord_b (
    .year_i (r1_q.year_b),
    .q100_i (qb1_q),
    .month_i(r1_q.month_b),
    .day_i  (r1_q.day_b),
    .info_o (info_b)
  );

  // Validate date A; advance date A by one day, rolling month and year.
  always_comb begin
    ok_d = (r1_q.month_a >= 4'd1) && (r1_q.month_a <= 4'd12)
        && (r1_q.day_a >= 5'd1) && (r1_q.day_a <= info_a.mlen);
    nd_d = 6'(r1_q.day_a) + 6'd1;
    nm_d = 5'(r1_q.month_a);
    ny_d = r1_q.year_a;
    if (nd_d > 6'(info_a.mlen)) begin
      nd_d = 6'd1;
      nm_d = nm_d + 5'd1;
      if (nm_d > 5'd12) begin
        nm_d = 5'd1;
        ny_d = r1_q.year_a + YearW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f2_q   <= r1_q.func;
    ord2_q <= ord1_q;
    ok2_q  <= ok_d;
    nd2_q  <= nd_d;
    nm2_q  <= nm_d[3:0];
    ny2_q  <= ny_d;
    oa2_q  <= info_a.ordinal;
    ob2_q  <= info_b.ordinal;
  end

  // Absolute ordinal difference; fields the operation does not produce are zero.
  assign diff = (oa2_q >= ob2_q) ? (oa2_q - ob2_q) : (ob2_q - oa2_q);

  always_comb begin
    res_d = '0;
    case (f2_q)
      FUNC_VALIDATE: res_d.is_valid = ok2_q;
      FUNC_COMPARE:  res_d.order    = ord2_q;
      FUNC_DIFF:     res_d.day_count = diff[21:0];
      FUNC_NEXT: begin
        res_d.next_day   = nd2_q;
        res_d.next_month = nm2_q;
        res_d.next_year  = ny2_q;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Every transfer yields exactly one result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("result missing three cycles after transfer");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 3))
    else $error("result without a matching transfer");

  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.order != 2'd3))
    else $error("compare result out of range");

  a_next_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.next_day <= 6'd32))
    else $error("next day out of range");

endmodule

>>> tb/sv/gregorian_date_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module gregorian_date_arithmetic_unit_tb;
  import gda_pkg::*;

  localparam int unsigned NUM_DIRECTED  = 25;
  localparam int unsigned NUM_RANDOM    = 1925;
  localparam int unsigned MAX_GAP       = 8;
  localparam int unsigned BURST_LEN     = 50;
  localparam int unsigned DRAIN_CYCLES  = 6;
  localparam int unsigned STALL_LIMIT   = 200;

  // Days in the months before month m of a common year; months 13 to 15 are
  // thirty days each and month 0 has nothing in front of it.
  localparam int unsigned MONTH_START [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 395, 425
  };

  // One directed row: the request, and a hand-written expectation where
  // one can be read off at a glance (typed), else the predictor decides.
  typedef struct {
    req_t req;
    logic typed;
    res_t exp;
  } dir_row_t;

  dir_row_t dir_tab [NUM_DIRECTED] = '{
    // validate: leap rule, year 0, month and day out of range, year 9999
    '{'{FUNC_VALIDATE, 5'd29, 4'd2, 14'd2000, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b1, '0, '0, '0, '0, '0}},
    '{'{FUNC_VALIDATE, 5'd29, 4'd2, 14'd1900, 5'd0, 4'd0, 14'd0}, 1'b1, '0},
    '{'{FUNC_VALIDATE, 5'd29, 4'd2, 14'd0, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b1, '0, '0, '0, '0, '0}},
    '{'{FUNC_VALIDATE, 5'd31, 4'd4, 14'd2023, 5'd0, 4'd0, 14'd0}, 1'b1, '0},
    '{'{FUNC_VALIDATE, 5'd1, 4'd0, 14'd2023, 5'd0, 4'd0, 14'd0}, 1'b1, '0},
    '{'{FUNC_VALIDATE, 5'd1, 4'd13, 14'd2023, 5'd0, 4'd0, 14'd0}, 1'b1, '0},
    '{'{FUNC_VALIDATE, 5'd0, 4'd1, 14'd2023, 5'd0, 4'd0, 14'd0}, 1'b1, '0},
    '{'{FUNC_VALIDATE, 5'd31, 4'd12, 14'd9999, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b1, '0, '0, '0, '0, '0}},
    '{'{FUNC_VALIDATE, 5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383}, 1'b0, '0},
    // compare: equal, year, month above 12, day, day 0
    '{'{FUNC_COMPARE, 5'd15, 4'd6, 14'd2020, 5'd15, 4'd6, 14'd2020}, 1'b1,
      '{1'b0, ORDER_EQUAL, '0, '0, '0, '0}},
    '{'{FUNC_COMPARE, 5'd1, 4'd1, 14'd0, 5'd31, 4'd15, 14'd16383}, 1'b1,
      '{1'b0, ORDER_EARLIER, '0, '0, '0, '0}},
    '{'{FUNC_COMPARE, 5'd1, 4'd15, 14'd2020, 5'd31, 4'd1, 14'd2020}, 1'b1,
      '{1'b0, ORDER_LATER, '0, '0, '0, '0}},
    '{'{FUNC_COMPARE, 5'd5, 4'd3, 14'd2020, 5'd4, 4'd3, 14'd2020}, 1'b1,
      '{1'b0, ORDER_LATER, '0, '0, '0, '0}},
    '{'{FUNC_COMPARE, 5'd0, 4'd3, 14'd2020, 5'd1, 4'd3, 14'd2020}, 1'b1,
      '{1'b0, ORDER_EARLIER, '0, '0, '0, '0}},
    // difference: same date, a leap year each way, widest span, month 13
    '{'{FUNC_DIFF, 5'd10, 4'd10, 14'd2010, 5'd10, 4'd10, 14'd2010}, 1'b1, '0},
    '{'{FUNC_DIFF, 5'd1, 4'd1, 14'd2000, 5'd1, 4'd1, 14'd2001}, 1'b1,
      '{1'b0, '0, 22'd366, '0, '0, '0}},
    '{'{FUNC_DIFF, 5'd1, 4'd3, 14'd2001, 5'd1, 4'd3, 14'd2000}, 1'b1,
      '{1'b0, '0, 22'd365, '0, '0, '0}},
    '{'{FUNC_DIFF, 5'd0, 4'd0, 14'd0, 5'd31, 4'd15, 14'd16383}, 1'b0, '0},
    '{'{FUNC_DIFF, 5'd1, 4'd13, 14'd2023, 5'd1, 4'd1, 14'd2024}, 1'b0, '0},
    // next date: year end, February both ways, 14-bit wrap, odd months
    '{'{FUNC_NEXT, 5'd31, 4'd12, 14'd9999, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b0, '0, '0, 6'd1, 4'd1, 14'd10000}},
    '{'{FUNC_NEXT, 5'd28, 4'd2, 14'd2023, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b0, '0, '0, 6'd1, 4'd3, 14'd2023}},
    '{'{FUNC_NEXT, 5'd28, 4'd2, 14'd2024, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b0, '0, '0, 6'd29, 4'd2, 14'd2024}},
    '{'{FUNC_NEXT, 5'd31, 4'd12, 14'd16383, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b0, '0, '0, 6'd1, 4'd1, 14'd0}},
    '{'{FUNC_NEXT, 5'd30, 4'd13, 14'd2023, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b0, '0, '0, 6'd1, 4'd1, 14'd2024}},
    '{'{FUNC_NEXT, 5'd30, 4'd0, 14'd2023, 5'd0, 4'd0, 14'd0}, 1'b1,
      '{1'b0, '0, '0, 6'd1, 4'd1, 14'd2023}}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  res_t res;

  // Expectation that travels with the request on the bus.
  logic row_typed = 1'b0;
  res_t row_exp   = '0;

  res_t        expected_results [$];
  int unsigned fail_count  = 0;
  int unsigned stall_count = 0;

  gregorian_date_arithmetic_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start_i (start),
    .busy_o  (busy),
    .req_i   (req),
    .done_o  (done),
    .res_o   (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------
  function automatic logic is_leap_year(input logic [13:0] y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // Month length; month 0 and months above 12 run thirty days.
  function automatic int unsigned days_in_month(input logic [3:0] m, input logic [13:0] y);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      4'd2:    return is_leap_year(y) ? 29 : 28;
      default: return 30;
    endcase
  endfunction

  // Day number counted from the start of year 0; the day field is taken as
  // it stands, so day 0 lands just before day 1.
  function automatic int unsigned day_number(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y);
    int unsigned yy;
    int unsigned n;
    yy = y;
    n  = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
    n  = n + MONTH_START[m] + d;
    if (m > 2 && is_leap_year(y)) n = n + 1;
    return n;
  endfunction

  function automatic res_t predict_date_op(input req_t r);
    res_t        o;
    int unsigned na;
    int unsigned nb;
    int unsigned span;
    o = '0;
    case (r.func)
      FUNC_VALIDATE: begin
        o.is_valid = (r.month_a >= 1) && (r.month_a <= 12) && (r.day_a >= 1) &&
                     (r.day_a <= days_in_month(r.month_a, r.year_a));
      end
      FUNC_COMPARE: begin
        // Year, then month, then day: a plain compare of the concatenation.
        if ({r.year_a, r.month_a, r.day_a} > {r.year_b, r.month_b, r.day_b})
          o.order = ORDER_LATER;
        else if ({r.year_a, r.month_a, r.day_a} < {r.year_b, r.month_b, r.day_b})
          o.order = ORDER_EARLIER;
        else
          o.order = ORDER_EQUAL;
      end
      FUNC_DIFF: begin
        na   = day_number(r.day_a, r.month_a, r.year_a);
        nb   = day_number(r.day_b, r.month_b, r.year_b);
        span = (na >= nb) ? na - nb : nb - na;
        o.day_count = span[21:0];
      end
      default: begin
        o.next_day   = 6'(r.day_a + 1);
        o.next_month = r.month_a;
        o.next_year  = r.year_a;
        if (r.day_a + 1 > days_in_month(r.month_a, r.year_a)) begin
          o.next_day = 6'd1;
          if (r.month_a >= 12) begin
            o.next_month = 4'd1;
            o.next_year  = r.year_a + 14'd1;
          end else begin
            o.next_month = r.month_a + 4'd1;
          end
        end
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------

  // Mostly real dates with a bias toward month ends; about one in five has
  // raw noise over the full day and month field widths.
  function automatic logic [22:0] random_date();
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    int unsigned len;
    case ($urandom_range(0, 9))
      0:       y = 14'($urandom_range(0, 16383));
      1:       y = 14'(100 * $urandom_range(0, 99));
      default: y = 14'($urandom_range(0, 9999));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      d = 5'($urandom);
      m = 4'($urandom);
    end else begin
      m   = 4'($urandom_range(1, 12));
      len = days_in_month(m, y);
      d   = ($urandom_range(0, 2) == 0) ? 5'(len) : 5'($urandom_range(1, len));
    end
    return {d, m, y};
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.func = func_e'(2'($urandom_range(0, 3)));
    {r.day_a, r.month_a, r.year_a} = random_date();
    {r.day_b, r.month_b, r.year_b} = random_date();
    // Share year, then month, then day with A so compare and difference
    // often hinge on the lower fields.
    if ($urandom_range(0, 2) != 0) begin
      r.year_b = r.year_a;
      if ($urandom_range(0, 1) != 0) begin
        r.month_b = r.month_a;
        if ($urandom_range(0, 1) != 0) r.day_b = r.day_a;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_field(input string name, input longint unsigned want,
                              input longint unsigned got);
    $error("%s: expected %0d, got %0d", name, want, got);
    fail_count++;
  endtask

  task automatic check_result(input res_t want, input res_t got);
    if (got.is_valid !== want.is_valid)     report_field("is_valid", want.is_valid, got.is_valid);
    if (got.order !== want.order)           report_field("order", want.order, got.order);
    if (got.day_count !== want.day_count)   report_field("day_count", want.day_count, got.day_count);
    if (got.next_day !== want.next_day)     report_field("next_day", want.next_day, got.next_day);
    if (got.next_month !== want.next_month)
      report_field("next_month", want.next_month, got.next_month);
    if (got.next_year !== want.next_year)   report_field("next_year", want.next_year, got.next_year);
  endtask

  // Sample at the rising edge: outputs and the request bus still hold the
  // values of the cycle that this edge ends. Check the result first, then
  // record the expectation of any transfer taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting");
          fail_count++;
        end else begin
          check_result(expected_results.pop_front(), res);
        end
      end
      if (start && !busy)
        expected_results.push_back(row_typed ? row_exp : predict_date_op(req));
      // Count cycles with no transfer and no result; give up after a while.
      if ((start && !busy) || done) begin
        stall_count <= 0;
      end else if (stall_count + 1 >= STALL_LIMIT) begin
        $display("gregorian_date_arithmetic_unit test failed");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------

  // Called at a rising edge. Hold start low for the idle gap, then present
  // the request and wait for the edge that takes it. With no gap, start
  // stays high from the previous transfer and only the payload advances.
  task automatic send_request(input req_t r, input logic typed, input res_t exp,
                              input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    req       <= r;
    row_typed <= typed;
    row_exp   <= exp;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int unsigned gap;
    logic        no_idle;
    no_idle = 1'b0;

    // Hold reset, then release it on an edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      gap = $urandom_range(0, MAX_GAP);
      send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].exp, gap);
    end

    // Random part; every so often switch to a stretch of back-to-back
    // transfers so the pipeline runs full.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % BURST_LEN == 0) no_idle = ($urandom_range(0, 2) == 0);
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      send_request(random_request(), 1'b0, '0, gap);
    end

    // Drop start, drain what is in flight, then keep watching for stray
    // results. The stall counter bounds the wait.
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("gregorian_date_arithmetic_unit test passed");
    else
      $display("gregorian_date_arithmetic_unit test failed");
    $finish;
  end

endmodule
